>>> hw/rtl/sic_pkg.sv
// shared types and constants of the sorted intersection counter
package sic_pkg;

  // payload widths fixed by the channel definition
  localparam int CMD_W       = 2;
  localparam int IN_ID_W     = 32;
  localparam int OUT_COUNT_W = 11;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic append_a;  // write element at the end of list a
    logic append_b;  // write element at the end of list b
    logic start;     // capture excluded ids, rewind pointers, zero the count
    logic step;      // one merge step on the registered read data
    logic finish;    // load the result register, empty both lists
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic more;      // both pointers inside their lists and the excluded ids differ
    logic out_free;  // result register can take a new result
  } dp_status_t;

endpackage

>>> hw/rtl/sic_if.sv
// channel interfaces of the sorted intersection counter
interface sic_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] element;
  logic [31:0] vertex_u;
  logic [31:0] vertex_v;

  modport source (output valid, output command, output element, output vertex_u,
                  output vertex_v, input ready);
  modport sink (input valid, input command, input element, input vertex_u,
                input vertex_v, output ready);
endinterface

interface sic_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] match_count;
  logic        overflow;

  modport source (output valid, output match_count, output overflow, input ready);
  modport sink (input valid, input match_count, input overflow, output ready);
endinterface

>>> hw/rtl/sorted_intersection_counter.sv
// top level of the sorted intersection counter
//
// in_chan carries command, element and two excluded vertex ids; out_chan
// carries match_count and overflow. a transfer happens when valid and ready
// are both high at a rising edge.
// load commands append one id to list a or list b; while the controller is
// idle, loads stream at one per cycle. a full list drops the id and raises
// overflow for the next result.
// a compute command walks both lists with a two-pointer merge, one step per
// cycle, reading each list memory through one registered read port. the
// result is registered once the walk has ended and the result register is
// free. a walk has at most len_a + len_b - 1 merge steps; in_ready stays
// low for the walk and the drain wait. both lists are then empty again.
// the result register holds while out_chan.ready is low; loads are still
// taken meanwhile, and a following compute waits at its end for the result
// register to drain.
// reset (synchronous, active low) empties both lists and the result register;
// the list memories themselves are never cleared, the fill counts cover them.
module sorted_intersection_counter
  import sic_pkg::*;
#(
  parameter int LIST_DEPTH = 1024,
  parameter int ID_BITS    = 32
) (
  input logic      clk,
  input logic      rst_n,
  sic_in_if.sink   in_chan,
  sic_out_if.source out_chan
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller
  sic_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath
  sic_dp #(
    .LIST_DEPTH (LIST_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .element         (in_chan.element),
    .vertex_u        (in_chan.vertex_u),
    .vertex_v        (in_chan.vertex_v),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_match_count (out_chan.match_count),
    .out_overflow    (out_chan.overflow)
  );

endmodule

>>> hw/rtl/sic_ctrl.sv
// controller state machine of the sorted intersection counter
module sic_ctrl
  import sic_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  input  dp_status_t       status,
  output dp_cmd_t          cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PRIME = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_command)
            CMD_LOAD_A: cmd.append_a = 1'b1;
            CMD_LOAD_B: cmd.append_b = 1'b1;
            CMD_COMPUTE: begin
              cmd.start = 1'b1;
              state_nxt = S_PRIME;
            end
            default: ;
          endcase
        end
      end
      // first reads of both lists are in flight
      S_PRIME: state_nxt = S_WALK;
      S_WALK: begin
        if (status.more) begin
          cmd.step = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // wait for the result register to drain
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/sic_dp.sv
// datapath of the sorted intersection counter: list memories, merge pointers, count
module sic_dp
  import sic_pkg::*;
#(
  parameter int LIST_DEPTH = 1024,
  parameter int ID_BITS    = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic [IN_ID_W-1:0]     element,
  input  logic [IN_ID_W-1:0]     vertex_u,
  input  logic [IN_ID_W-1:0]     vertex_v,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [OUT_COUNT_W-1:0] out_match_count,
  output logic                   out_overflow
);

  localparam int IdW = (ID_BITS < IN_ID_W) ? ID_BITS : IN_ID_W;
  localparam int AW  = $clog2(LIST_DEPTH);
  localparam int LW  = $clog2(LIST_DEPTH + 1);
  localparam int CW  = (LW > OUT_COUNT_W) ? LW : OUT_COUNT_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(LIST_DEPTH);

  logic [IdW-1:0] mem_a [LIST_DEPTH];
  logic [IdW-1:0] mem_b [LIST_DEPTH];
  logic [IdW-1:0] rd_a_r, rd_b_r;

  logic [LW-1:0]  len_a_r, len_a_nxt, len_b_r, len_b_nxt;
  logic           drop_r, drop_nxt;
  logic [LW-1:0]  ia_r, ia_nxt, ib_r, ib_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [IdW-1:0] u_r, v_r;

  logic           out_valid_r, out_valid_nxt;
  logic [OUT_COUNT_W-1:0] out_count_r;
  logic           out_ovf_r;

  logic           wr_a, wr_b;
  logic [AW-1:0]  rd_addr_a, rd_addr_b;
  logic           eq, a_lt, hit;

  // appends into a full list are dropped
  assign wr_a = cmd.append_a && (len_a_r != DEPTH_L);
  assign wr_b = cmd.append_b && (len_b_r != DEPTH_L);

  // merge compare on the registered read data
  assign eq   = (rd_a_r == rd_b_r);
  assign a_lt = (rd_a_r < rd_b_r);
  assign hit  = eq && (rd_a_r != u_r) && (rd_a_r != v_r);

  assign status.more     = (ia_r < len_a_r) && (ib_r < len_b_r) && (u_r != v_r);
  assign status.out_free = !out_valid_r || out_ready;

  // pointers, count, lengths and overflow flag
  always_comb begin
    ia_nxt    = ia_r;
    ib_nxt    = ib_r;
    count_nxt = count_r;
    len_a_nxt = len_a_r;
    len_b_nxt = len_b_r;
    drop_nxt  = drop_r;
    if (cmd.start) begin
      ia_nxt    = '0;
      ib_nxt    = '0;
      count_nxt = '0;
    end else if (cmd.step) begin
      if (eq || a_lt) begin
        ia_nxt = ia_r + LW'(1);
      end
      if (eq || !a_lt) begin
        ib_nxt = ib_r + LW'(1);
      end
      if (hit) begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (wr_a) begin
      len_a_nxt = len_a_r + LW'(1);
    end
    if (wr_b) begin
      len_b_nxt = len_b_r + LW'(1);
    end
    if ((cmd.append_a && !wr_a) || (cmd.append_b && !wr_b)) begin
      drop_nxt = 1'b1;
    end
    if (cmd.finish) begin
      len_a_nxt = '0;
      len_b_nxt = '0;
      drop_nxt  = 1'b0;
    end
  end

  // during the walk the read addresses use the next pointer values, so the read data lines up with the pointers
  assign rd_addr_a = cmd.step ? ia_nxt[AW-1:0] : ia_r[AW-1:0];
  assign rd_addr_b = cmd.step ? ib_nxt[AW-1:0] : ib_r[AW-1:0];

  // list memories
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[len_a_r[AW-1:0]] <= element[IdW-1:0];
    end
    rd_a_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[len_b_r[AW-1:0]] <= element[IdW-1:0];
    end
    rd_b_r <= mem_b[rd_addr_b];
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r     <= '0;
      len_b_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_a_r     <= len_a_nxt;
      len_b_r     <= len_b_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk and result payload registers
  always_ff @(posedge clk) begin
    ia_r    <= ia_nxt;
    ib_r    <= ib_nxt;
    count_r <= count_nxt;
    if (cmd.start) begin
      u_r <= vertex_u[IdW-1:0];
      v_r <= vertex_v[IdW-1:0];
    end
    if (cmd.finish) begin
      out_count_r <= count_r[OUT_COUNT_W-1:0];
      out_ovf_r   <= drop_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_count = out_count_r;
  assign out_overflow    = out_ovf_r;

endmodule

>>> hw/rtl/sic_checker.sv
// port level checks of the sorted intersection counter and their binding
module sic_checker
  import sic_pkg::*;
#(
  parameter int LIST_DEPTH = 1024
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [CMD_W-1:0]       in_command,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [OUT_COUNT_W-1:0] out_match_count,
  input logic                   out_overflow
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_match_count) && $stable(out_overflow)))
    else $error("result payload changed while stalled");

  // a compute transfer starts the walk, so the input closes next cycle
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == CMD_COMPUTE)) |=> !in_ready)
    else $error("input open right after a compute transfer");

  // a reported count never exceeds the list depth, checked for depths up to 2047
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((LIST_DEPTH > 2047) || (int'(out_match_count) <= LIST_DEPTH)))
    else $error("match count beyond list depth");

endmodule

bind sorted_intersection_counter sic_checker #(
  .LIST_DEPTH (LIST_DEPTH)
) u_sic_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_command      (in_chan.command),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_match_count (out_chan.match_count),
  .out_overflow    (out_chan.overflow)
);
